// File: design/rmsl_pkg.sv
// ----------------------------------------------------------------------------
// rmsl_pkg: shared types and constants of the block rms level meter
// Register indexes, controller states and fixed widths of the serial units.
// ----------------------------------------------------------------------------
package rmsl_pkg;

	// fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int LEVEL_W    = 15;
	localparam int INDEX_W    = 7;
	localparam int RMS_W      = 16;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int BLEN_W     = 11;
	localparam int BPG_W      = 5;
	localparam int BPF_W      = 8;
	localparam int GCNT_W     = 4;

	// serial multiplier operand width and log fraction bits
	localparam int MUL_W      = 31;
	localparam int LOG_FRAC_W = 16;
	localparam int LOG_IT_W   = 4;

	// 10*log10(2) in Q.16, applied to log2 in Q.16
	localparam logic [MUL_W-1:0] DB_SCALE = 31'd197283;
	localparam logic [LEVEL_W-1:0] LEVEL_SAT = 15'h7fff;
	localparam logic [RMS_W-1:0] RMS_SAT = 16'hffff;

	localparam logic [BPG_W-1:0] BPG_MAX = 5'd16;
	localparam logic [BPF_W-1:0] BPF_MAX = 8'd128;

	localparam logic [BLEN_W-1:0] BLEN_RST = 11'd200;
	localparam logic [BPG_W-1:0] BPG_RST = 5'd10;
	localparam logic [BPF_W-1:0] BPF_RST = 8'd80;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_LENGTH     = 2'd0,
		REG_BLOCKS_PER_GROUP = 2'd1,
		REG_BLOCKS_PER_FRAME = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_WAIT,
		ST_LDIV_GO,
		ST_LDIV_WAIT,
		ST_NORM,
		ST_LOG_GO,
		ST_LOG_WAIT,
		ST_SCALE_GO,
		ST_SCALE_WAIT,
		ST_GRP,
		ST_GDIV_GO,
		ST_GDIV_WAIT,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_FIN
	} rmsl_state_t;

endpackage

// File: design/rmsl_mul.sv
// ----------------------------------------------------------------------------
// rmsl_mul: bit-serial shift-add multiplier
// One multiplier bit per cycle, product ready when done is raised.
// ----------------------------------------------------------------------------
module rmsl_mul
	import rmsl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic                 done,
	output logic [2*MUL_W-1:0]   prod
);

	localparam int CNT_W = $clog2(MUL_W);

	logic [MUL_W-1:0]   a_q;
	logic [MUL_W-1:0]   b_q;
	logic [2*MUL_W-1:0] prod_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_W:0]     psum;
	logic               last;

	// partial product added into the upper half
	assign psum = {1'b0, prod_q[2*MUL_W-1:MUL_W]} + (b_q[0] ? {1'b0, a_q} : '0);
	assign last = (cnt_q == CNT_W'(MUL_W-1));

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// operand and product shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= {psum, prod_q[MUL_W-1:1]};
			b_q    <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// File: design/rmsl_div.sv
// ----------------------------------------------------------------------------
// rmsl_div: bit-serial restoring divider
// One quotient bit per cycle, quotient ready when done is raised.
// ----------------------------------------------------------------------------
module rmsl_div
	import rmsl_pkg::*;
#(
	parameter int DW = 57,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot
);

	localparam int CNT_W = $clog2(DW);

	logic [VW-1:0]    div_q;
	logic [VW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      trial;
	logic [VW:0]      diff;
	logic             ge;
	logic             last;

	// bring down the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});
	assign last  = (cnt_q == CNT_W'(DW-1));

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: design/rmsl_sqrt.sv
// ----------------------------------------------------------------------------
// rmsl_sqrt: digit-serial integer square root
// Two radicand bits per cycle, one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
module rmsl_sqrt
	import rmsl_pkg::*;
#(
	parameter int IW = 45
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [IW-1:0]         radicand,
	output logic                  done,
	output logic [(IW+1)/2-1:0]   root
);

	localparam int RT_W  = (IW + 1) / 2;
	localparam int PW    = 2 * RT_W;
	localparam int CNT_W = $clog2(RT_W);

	logic [PW-1:0]     v_q;
	logic [RT_W+1:0]   rem_q;
	logic [RT_W-1:0]   root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RT_W+3:0]   tr;
	logic [RT_W+3:0]   trial;
	logic [RT_W+3:0]   diff;
	logic              ge;
	logic              last;

	// next bit pair against 4*root + 1
	assign tr    = {rem_q, v_q[PW-1:PW-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = tr - trial;
	assign ge    = (tr >= trial);
	assign last  = (cnt_q == CNT_W'(RT_W-1));

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// radicand, remainder and root registers
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= PW'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= v_q << 2;
			rem_q  <= ge ? diff[RT_W+1:0] : tr[RT_W+1:0];
			root_q <= {root_q[RT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: design/block_rms_level_meter_top.sv
// ----------------------------------------------------------------------------
// block_rms_level_meter_top: block rms level meter
// Sums squared samples per block and reports block level in dB, group rms
// and frame min/max with bit-serial units: shared multiply and divide, a root.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one signed sample per word (in_valid / in_stall).
//   Output channel: one result word per closed block (out_valid / out_stall).
//   Configuration: cfg_we, cfg_index, cfg_data, written while the block idles.
// Sequence
//   A sample that does not close a block is accepted, squared in the
//   bit-serial multiplier and accumulated.
//   A closing sample adds the level path: a divide of the R_W-bit ratio
//   (R_W = 57 at the default MAX_BLOCK_LENGTH), normalise shifts, 16 log
//   squarings and a scale, all skipped but the divide for a zero level;
//   a group close adds another divide and a square root.
//   The result word is registered; the next sample is taken while it waits.
// Reset
//   All counters and sums clear, registers return to 200 / 10 / 80.
// Stall
//   A stalled result holds; a further block close waits until it is taken.
// ----------------------------------------------------------------------------
module block_rms_level_meter_top
	import rmsl_pkg::*;
#(
	parameter int MAX_BLOCK_LENGTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [LEVEL_W-1:0]         level_db,
	output logic [INDEX_W-1:0]         block_index,
	output logic                       group_valid,
	output logic [RMS_W-1:0]           group_rms,
	output logic                       frame_last,
	output logic [LEVEL_W-1:0]         frame_min_db,
	output logic [LEVEL_W-1:0]         frame_max_db,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	localparam int CNT_W  = $clog2(MAX_BLOCK_LENGTH + 1);
	localparam int BS_W   = 30 + CNT_W;
	localparam int GS_W   = BS_W + 4;
	localparam int R_W    = BS_W + 16;
	localparam int DV_W   = CNT_W + 5;
	localparam int SH_W   = $clog2(R_W);
	localparam int EXP_W  = $clog2(R_W - 16);
	localparam int GRT_W  = (GS_W + 1) / 2;

	rmsl_state_t state_q, state_nx;

	// configuration registers
	logic [BLEN_W-1:0] blen_q;
	logic [BPG_W-1:0]  bpg_q;
	logic [BPF_W-1:0]  bpf_q;

	// running state
	logic [BS_W-1:0]    block_sum_q;
	logic [GS_W-1:0]    group_sum_q;
	logic [CNT_W-1:0]   sample_count_q;
	logic [INDEX_W-1:0] block_count_q;
	logic [GCNT_W-1:0]  group_block_count_q;
	logic [LEVEL_W-1:0] min_q;
	logic [LEVEL_W-1:0] max_q;

	// block-end scratch
	logic [R_W-1:0]        r_q;
	logic [SH_W-1:0]       sh_q;
	logic [MUL_W-1:0]      m_q;
	logic [LOG_FRAC_W-1:0] frac_q;
	logic [LOG_IT_W-1:0]   it_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [RMS_W-1:0]      grms_q;
	logic                  gvalid_q;

	// result word
	logic               out_valid_q;
	logic [LEVEL_W-1:0] level_out_q;
	logic [INDEX_W-1:0] index_out_q;
	logic               gvalid_out_q;
	logic [RMS_W-1:0]   grms_out_q;
	logic               flast_out_q;
	logic [LEVEL_W-1:0] fmin_out_q;
	logic [LEVEL_W-1:0] fmax_out_q;

	// unit connections
	logic                 mul_start;
	logic [MUL_W-1:0]     mul_a;
	logic                 mul_done;
	logic [2*MUL_W-1:0]   mul_prod;
	logic                 div_start;
	logic [R_W-1:0]       div_dividend;
	logic [DV_W-1:0]      div_divisor;
	logic                 div_done;
	logic [R_W-1:0]       div_quot;
	logic                 sqrt_start;
	logic                 sqrt_done;
	logic [GRT_W-1:0]     sqrt_root;

	// derived values
	logic [CNT_W-1:0]     len;
	logic [BPG_W-1:0]     bpg;
	logic [BPF_W-1:0]     bpf;
	logic [SAMPLE_W-1:0]  mag;
	logic                 accept;
	logic [CNT_W-1:0]     cnt_nx;
	logic [BS_W-1:0]      sum_nx;
	logic                 block_close;
	logic                 level_zero;
	logic [EXP_W-1:0]     lg_exp;
	logic [31:0]          sqv;
	logic [2*MUL_W-25:0]  scaled;
	logic [BPG_W-1:0]     gbc_nx;
	logic                 gclose;
	logic [BPF_W-1:0]     bc_nx;
	logic                 fclose;
	logic [LEVEL_W-1:0]   min_nx;
	logic [LEVEL_W-1:0]   max_nx;
	logic                 out_free;
	logic                 fin_load;

	// register clamps
	always_comb begin
		if (blen_q == '0) begin
			len = CNT_W'(1);
		end else if (32'(blen_q) > MAX_BLOCK_LENGTH) begin
			len = CNT_W'(MAX_BLOCK_LENGTH);
		end else begin
			len = CNT_W'(blen_q);
		end
		if (bpg_q == '0) begin
			bpg = BPG_W'(1);
		end else if (bpg_q > BPG_MAX) begin
			bpg = BPG_MAX;
		end else begin
			bpg = bpg_q;
		end
		if (bpf_q == '0) begin
			bpf = BPF_W'(1);
		end else if (bpf_q > BPF_MAX) begin
			bpf = BPF_MAX;
		end else begin
			bpf = bpf_q;
		end
	end

	// sample magnitude and block accumulation
	assign mag         = sample[SAMPLE_W-1] ? (~$unsigned(sample) + SAMPLE_W'(1))
	                                        : $unsigned(sample);
	assign accept      = in_valid && !in_stall;
	assign cnt_nx      = sample_count_q + CNT_W'(1);
	assign sum_nx      = block_sum_q + mul_prod[BS_W-1:0];
	assign block_close = (cnt_nx >= len);

	// log path
	assign level_zero = (div_quot[R_W-1:16] == '0);
	assign lg_exp     = EXP_W'(R_W - 17) - EXP_W'(sh_q);
	assign sqv        = mul_prod[2*MUL_W-1:30];
	assign scaled     = mul_prod[2*MUL_W-1:24];

	// group and frame bookkeeping
	assign gbc_nx   = {1'b0, group_block_count_q} + BPG_W'(1);
	assign gclose   = (gbc_nx >= bpg);
	assign bc_nx    = {1'b0, block_count_q} + BPF_W'(1);
	assign fclose   = (bc_nx >= bpf);
	assign min_nx   = (level_q < min_q) ? level_q : min_q;
	assign max_nx   = (level_q > max_q) ? level_q : max_q;
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_nx = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				if (mul_done) state_nx = block_close ? ST_LDIV_GO : ST_IDLE;
			end
			ST_LDIV_GO:   state_nx = ST_LDIV_WAIT;
			ST_LDIV_WAIT: begin
				if (div_done) state_nx = level_zero ? ST_GRP : ST_NORM;
			end
			ST_NORM: begin
				if (r_q[R_W-1]) state_nx = ST_LOG_GO;
			end
			ST_LOG_GO:    state_nx = ST_LOG_WAIT;
			ST_LOG_WAIT: begin
				if (mul_done) begin
					state_nx = (it_q == LOG_IT_W'(LOG_FRAC_W-1)) ? ST_SCALE_GO : ST_LOG_GO;
				end
			end
			ST_SCALE_GO:  state_nx = ST_SCALE_WAIT;
			ST_SCALE_WAIT: begin
				if (mul_done) state_nx = ST_GRP;
			end
			ST_GRP:       state_nx = gclose ? ST_GDIV_GO : ST_FIN;
			ST_GDIV_GO:   state_nx = ST_GDIV_WAIT;
			ST_GDIV_WAIT: begin
				if (div_done) state_nx = ST_SQRT_GO;
			end
			ST_SQRT_GO:   state_nx = ST_SQRT_WAIT;
			ST_SQRT_WAIT: begin
				if (sqrt_done) state_nx = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default:      state_nx = ST_IDLE;
		endcase
	end

	// controller outputs and unit operand selection
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		mul_start    = 1'b0;
		mul_a        = MUL_W'(mag);
		div_start    = 1'b0;
		div_dividend = {block_sum_q, 16'b0};
		div_divisor  = DV_W'(sample_count_q);
		sqrt_start   = 1'b0;
		fin_load     = 1'b0;
		unique case (state_q)
			ST_IDLE:     mul_start = in_valid;
			ST_LOG_GO: begin
				mul_start = 1'b1;
				mul_a     = m_q;
			end
			ST_SCALE_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_W'({lg_exp, frac_q});
			end
			ST_LDIV_GO:  div_start = 1'b1;
			ST_GDIV_GO: begin
				div_start    = 1'b1;
				div_dividend = R_W'(group_sum_q);
				div_divisor  = DV_W'(DV_W'(bpg) * DV_W'(len));
			end
			ST_SQRT_GO:  sqrt_start = 1'b1;
			ST_FIN:      fin_load = out_free;
			default: ;
		endcase
	end

	// squaring, log squaring and scaling share one serial multiplier
	rmsl_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      ((state_q == ST_SCALE_GO) ? DB_SCALE : mul_a),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// level ratio and group mean share one serial divider
	rmsl_div #(
		.DW (R_W),
		.VW (DV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	rmsl_sqrt #(
		.IW (GS_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quot[GS_W-1:0]),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q <= BLEN_RST;
			bpg_q  <= BPG_RST;
			bpf_q  <= BPF_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BLOCK_LENGTH:     blen_q <= cfg_data[BLEN_W-1:0];
				REG_BLOCKS_PER_GROUP: bpg_q  <= cfg_data[BPG_W-1:0];
				REG_BLOCKS_PER_FRAME: bpf_q  <= cfg_data[BPF_W-1:0];
				default: ;
			endcase
		end
	end

	// controller state and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			block_sum_q         <= '0;
			group_sum_q         <= '0;
			sample_count_q      <= '0;
			block_count_q       <= '0;
			group_block_count_q <= '0;
			min_q               <= LEVEL_SAT;
			max_q               <= '0;
			it_q                <= '0;
			out_valid_q         <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_SQ_WAIT && mul_done) begin
				block_sum_q    <= sum_nx;
				sample_count_q <= cnt_nx;
			end
			if (state_q == ST_NORM) begin
				it_q <= '0;
			end else if (state_q == ST_LOG_WAIT && mul_done) begin
				it_q <= it_q + LOG_IT_W'(1);
			end
			if (state_q == ST_GRP) begin
				group_sum_q         <= group_sum_q + GS_W'(block_sum_q);
				group_block_count_q <= gclose ? '0 : gbc_nx[GCNT_W-1:0];
			end
			if (state_q == ST_SQRT_WAIT && sqrt_done) begin
				group_sum_q <= '0;
			end
			if (fin_load) begin
				block_sum_q    <= '0;
				sample_count_q <= '0;
				if (fclose) begin
					block_count_q <= '0;
					min_q         <= LEVEL_SAT;
					max_q         <= '0;
				end else begin
					block_count_q <= bc_nx[INDEX_W-1:0];
					min_q         <= min_nx;
					max_q         <= max_nx;
				end
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// block-end datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_LDIV_WAIT && div_done) begin
			r_q     <= div_quot;
			sh_q    <= '0;
			level_q <= '0;
			frac_q  <= '0;
		end
		// normalise so the top bit of the ratio sits at the msb
		if (state_q == ST_NORM && !r_q[R_W-1]) begin
			r_q  <= r_q << 1;
			sh_q <= sh_q + SH_W'(1);
		end
		if (state_q == ST_NORM && r_q[R_W-1]) begin
			m_q <= r_q[R_W-1 -: MUL_W];
		end
		// one fraction bit per squaring
		if (state_q == ST_LOG_WAIT && mul_done) begin
			frac_q <= {frac_q[LOG_FRAC_W-2:0], sqv[31]};
			m_q    <= sqv[31] ? sqv[31:1] : sqv[30:0];
		end
		if (state_q == ST_SCALE_WAIT && mul_done) begin
			level_q <= (|scaled[$bits(scaled)-1:LEVEL_W]) ? LEVEL_SAT : scaled[LEVEL_W-1:0];
		end
		if (state_q == ST_GRP) begin
			gvalid_q <= gclose;
			grms_q   <= '0;
		end
		if (state_q == ST_SQRT_WAIT && sqrt_done) begin
			grms_q <= (|sqrt_root[GRT_W-1:RMS_W]) ? RMS_SAT : sqrt_root[RMS_W-1:0];
		end
		// result word
		if (fin_load) begin
			level_out_q  <= level_q;
			index_out_q  <= block_count_q;
			gvalid_out_q <= gvalid_q;
			grms_out_q   <= grms_q;
			flast_out_q  <= fclose;
			fmin_out_q   <= fclose ? min_nx : '0;
			fmax_out_q   <= fclose ? max_nx : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign level_db     = level_out_q;
	assign block_index  = index_out_q;
	assign group_valid  = gvalid_out_q;
	assign group_rms    = grms_out_q;
	assign frame_last   = flast_out_q;
	assign frame_min_db = fmin_out_q;
	assign frame_max_db = fmax_out_q;

endmodule

// File: design/rmsl_checker.sv
// ----------------------------------------------------------------------------
// rmsl_checker: port-level checks of the block rms level meter
// Watches the result channel and its flags; bound to the top level.
// ----------------------------------------------------------------------------
module rmsl_checker
	import rmsl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [LEVEL_W-1:0] level_db,
	input  logic               group_valid,
	input  logic [RMS_W-1:0]   group_rms,
	input  logic               frame_last,
	input  logic [LEVEL_W-1:0] frame_min_db,
	input  logic [LEVEL_W-1:0] frame_max_db
);

	// stalled word stays valid with its level unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(level_db))
		else $error("result word dropped or changed under stall");

	// group rms only on a group close
	a_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !group_valid |-> group_rms == '0)
		else $error("group rms set without group close");

	// frame extremes only on a frame close
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_last |-> frame_min_db == '0 && frame_max_db == '0)
		else $error("frame extremes set without frame close");

	// frame minimum not above frame maximum
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> frame_min_db <= frame_max_db)
		else $error("frame minimum above maximum");

endmodule

bind block_rms_level_meter_top rmsl_checker u_rmsl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.level_db     (level_db),
	.group_valid  (group_valid),
	.group_rms    (group_rms),
	.frame_last   (frame_last),
	.frame_min_db (frame_min_db),
	.frame_max_db (frame_max_db)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the block rms level meter
// Streams signed samples under several block, group and frame settings,
// predicts every block result (dB level, group rms, frame min/max) and
// compares each result word against the expected word, with random idling, a long
// output hold-off and a quiet tail.
// ----------------------------------------------------------------------------
module tb_top;
	import rmsl_pkg::*;

	localparam int MAX_BLEN    = 1024;
	localparam int SETTLE      = 64;
	localparam int DRAIN       = 1000;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 3000;
	localparam int PHASE_ITEMS = 24;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [LEVEL_W-1:0] MIN_RST = 15'h7fff;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [INDEX_W-1:0] idx;
		logic               gvalid;
		logic [RMS_W-1:0]   grms;
		logic               flast;
		logic [LEVEL_W-1:0] fmin;
		logic [LEVEL_W-1:0] fmax;
	} block_word_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] smp;
		bit                         typed;
		block_word_t                word;
	} row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_stall;
	logic [LEVEL_W-1:0]         level_db;
	logic [INDEX_W-1:0]         block_index;
	logic                       group_valid;
	logic [RMS_W-1:0]           group_rms;
	logic                       frame_last;
	logic [LEVEL_W-1:0]         frame_min_db;
	logic [LEVEL_W-1:0]         frame_max_db;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;

	block_rms_level_meter_top #(.MAX_BLOCK_LENGTH(MAX_BLEN)) dut (.*);

	// predictor copy of registers and state
	logic [BLEN_W-1:0] m_blen;
	logic [BPG_W-1:0]  m_bpg;
	logic [BPF_W-1:0]  m_bpf;
	longint unsigned   m_block_sum, m_group_sum;
	int unsigned       m_samples, m_blocks, m_group_blocks;
	logic [LEVEL_W-1:0] m_min, m_max;

	block_word_t expected_words[$];
	int errors, n_items, n_words, n_groups, n_frames, cycles;
	bit quiet;
	int hold_req, hold_seen;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// log2 by repeated squaring, scaled to dB in Q7.8
	function automatic logic [LEVEL_W-1:0] db_from_sum(longint unsigned sum, int unsigned n);
		longint unsigned r, m, lg;
		int unsigned p;
		longint unsigned frac;
		r = (sum << 16) / n;
		if (r < 64'd65536) return '0;
		p = 0;
		while (p < 63 && (r >> (p + 1)) != 0) p++;
		m = (p >= 30) ? (r >> (p - 30)) : (r << (30 - p));
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		lg = ((longint'(p) - 16) << 16) | frac;
		lg = (lg * 64'd197283) >> 24;
		return (lg > 64'd32767) ? LEVEL_SAT : lg[LEVEL_W-1:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic void meter_reset();
		m_blen = BLEN_RST;
		m_bpg = BPG_RST;
		m_bpf = BPF_RST;
		m_block_sum = 0;
		m_group_sum = 0;
		m_samples = 0;
		m_blocks = 0;
		m_group_blocks = 0;
		m_min = MIN_RST;
		m_max = '0;
	endfunction

	// advance the predictor by one sample; returns 1 when a block closes
	function automatic bit meter_step(logic signed [SAMPLE_W-1:0] s, output block_word_t w);
		int unsigned len, bpg, bpf, mag;
		longint unsigned q, r;
		len = clamp_reg(m_blen, MAX_BLEN);
		bpg = clamp_reg(m_bpg, 16);
		bpf = clamp_reg(m_bpf, 128);
		w = '0;
		mag = (s < 0) ? -int'(s) : int'(s);
		m_block_sum += longint'(mag) * mag;
		m_samples++;
		if (m_samples < len) return 0;
		w.level = db_from_sum(m_block_sum, m_samples);
		m_group_sum += m_block_sum;
		m_block_sum = 0;
		m_samples = 0;
		m_group_blocks++;
		if (m_group_blocks >= bpg) begin
			q = m_group_sum / (longint'(bpg) * len);
			r = int_sqrt(q);
			w.grms = (r > 64'd65535) ? RMS_SAT : r[RMS_W-1:0];
			w.gvalid = 1'b1;
			m_group_sum = 0;
			m_group_blocks = 0;
		end
		if (w.level < m_min) m_min = w.level;
		if (w.level > m_max) m_max = w.level;
		w.idx = m_blocks[INDEX_W-1:0];
		m_blocks++;
		if (m_blocks >= bpf) begin
			w.flast = 1'b1;
			w.fmin = m_min;
			w.fmax = m_max;
			m_min = MIN_RST;
			m_max = '0;
			m_blocks = 0;
		end
		return 1;
	endfunction

	// offer one word, with an optional random gap before it
	task automatic send_sample(logic signed [SAMPLE_W-1:0] s, bit typed, block_word_t tw);
		block_word_t w;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (in_stall);
		n_items++;
		if (meter_step(s, w)) expected_words.push_back(typed ? tw : w);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BLOCK_LENGTH:     m_blen = val[BLEN_W-1:0];
			REG_BLOCKS_PER_GROUP: m_bpg = val[BPG_W-1:0];
			REG_BLOCKS_PER_FRAME: m_bpf = val[BPF_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int blen, int bpg, int bpf);
		write_reg(REG_BLOCK_LENGTH, CFG_W'(blen));
		write_reg(REG_BLOCKS_PER_GROUP, CFG_W'(bpg));
		write_reg(REG_BLOCKS_PER_FRAME, CFG_W'(bpf));
	endtask

	// mix of full range, near silence, extremes and mid-size samples
	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		logic signed [SAMPLE_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = SAMPLE_W'($urandom_range(0, 3));
			1: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2: v = 16'sh0000;
			3: v = SAMPLE_W'($urandom_range(0, 1023));
			default: v = SAMPLE_W'($urandom);
		endcase
		if ($urandom_range(0, 1) && v != 16'sh8000) v = -v;
		return v;
	endfunction

	// check accepted result words; receiver idling and long hold-off
	int stall_left, hold_left;
	always @(posedge clk) begin
		block_word_t got, exp_w;
		if (out_valid && !out_stall) begin
			got = '{level_db, block_index, group_valid, group_rms, frame_last,
				frame_min_db, frame_max_db};
			n_words++;
			if (group_valid) n_groups++;
			if (frame_last) n_frames++;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %p", got);
			end else begin
				exp_w = expected_words.pop_front();
				if (got != exp_w) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at word %0d\n  exp %p\n  got %p", n_words, exp_w, got);
				end
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	row_t dir_rows[$];

	initial begin
		block_word_t nw;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BLOCK_LENGTH;
		cfg_data = '0;
		quiet = 1'b0;
		meter_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one full 200-sample block
		repeat (200) send_sample(rand_sample(), 0, nw);
		wait_idle();

		// directed table: one sample per block, group and frame
		// the first row also closes the group and frame left open above
		set_config(1, 1, 1);
		write_reg(REG_UNUSED, 11'h7ff);
		dir_rows = '{
			'{16'sh0000, 0, '0},
			'{16'sh0001, 1, '{15'd0, 7'd0, 1'b1, 16'd1, 1'b1, 15'd0, 15'd0}},
			'{-16'sh0001, 1, '{15'd0, 7'd0, 1'b1, 16'd1, 1'b1, 15'd0, 15'd0}},
			'{16'sh7fff, 0, '0}, '{16'sh8000, 0, '0}, '{16'sh8001, 0, '0},
			'{16'sh5555, 0, '0}, '{16'shaaaa, 0, '0}, '{16'sh0002, 0, '0},
			'{16'sh00ff, 0, '0}, '{16'sh0100, 0, '0}, '{-16'sh0100, 0, '0},
			'{16'sh4000, 0, '0}, '{16'sh1234, 0, '0}
		};
		foreach (dir_rows[i]) send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].word);
		wait_idle();
		// zero registers clamp to one
		set_config(0, 0, 0);
		repeat (4) send_sample(rand_sample(), 0, nw);
		wait_idle();

		// random phases over a spread of settings
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_config(2, 16, 128);
				1: set_config(3, 31, 255);
				2: set_config(1, 3, 5);
				3: set_config(5, $urandom_range(0, 31), $urandom_range(0, 255));
				4: set_config(1, 16, 1);
				5: set_config(4, 2, 129);
				default: set_config($urandom_range(1, 8), $urandom_range(1, 16),
					$urandom_range(1, 20));
			endcase
			if (ph == 2) hold_req++;
			repeat (PHASE_ITEMS) send_sample(rand_sample(), 0, nw);
			wait_idle();
		end

		// quiet tail: no idling on either side
		quiet = 1'b1;
		set_config(2, 3, 5);
		repeat (PHASE_ITEMS) send_sample(rand_sample(), 0, nw);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d samples in, %0d block words checked (%0d group, %0d frame ends)",
			n_items, n_words, n_groups, n_frames);
		$display("settings spanned block length 1..200, groups 1..16, frames 1..128");
		if (errors == 0 && expected_words.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d words missing", errors, expected_words.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/rmsl_pkg.sv
design/rmsl_mul.sv
design/rmsl_div.sv
design/rmsl_sqrt.sv
design/block_rms_level_meter_top.sv
design/rmsl_checker.sv
sim/tb_top.sv
